>>> rtl/pcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcp_pkg
// shared types and constants of the collision time predictor
// ---------------------------------------------------------------------------
package pcp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int KIND_W = 2;
    localparam int POS_W  = 17;
    localparam int VEL_W  = 19;
    localparam int RAD_W  = 15;
    localparam int TIME_W = 23;
    localparam int HOR_W  = 23;
    localparam int GAP_W  = 10;
    localparam int EV_W   = 25;

    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 32;

    localparam int BM_W   = 37;
    localparam int VV_W   = 40;
    localparam int D_W    = 76;
    localparam int ROOT_W = 38;
    localparam int N_W    = 38;
    localparam int DD_W   = 40;
    localparam int INT_W  = 24;
    localparam int Q_W    = INT_W + FRAC_BITS;
    localparam int MAG_W  = Q_W + 1;
    localparam int EVX_W  = MAG_W + 2;

    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << Q_W;
    localparam logic signed [19:0] WALL_ONE = 20'sd1 <<< FRAC_BITS;
    localparam logic signed [EVX_W-1:0] EV_MAX = (EVX_W'(1) <<< (EV_W - 1)) - 1;
    localparam logic signed [EVX_W-1:0] EV_MIN = -(EVX_W'(1) <<< (EV_W - 1));

    localparam logic [HOR_W-1:0] HORIZON_RESET = 23'd655360;
    localparam logic [GAP_W-1:0] GAP_RESET     = 10'd66;

    typedef enum logic [1:0] {
        KIND_BALL   = 2'd0,
        KIND_WALL_X = 2'd1,
        KIND_WALL_Y = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_HORIZON = 1'b0,
        CFG_GAP     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos_x_a;
        logic [POS_W-1:0]  pos_y_a;
        logic [VEL_W-1:0]  vel_x_a;
        logic [VEL_W-1:0]  vel_y_a;
        logic [RAD_W-1:0]  radius_a;
        logic [POS_W-1:0]  pos_x_b;
        logic [POS_W-1:0]  pos_y_b;
        logic [VEL_W-1:0]  vel_x_b;
        logic [VEL_W-1:0]  vel_y_b;
        logic [RAD_W-1:0]  radius_b;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic              kill;
        logic              ball;
        logic              wneg;
        logic [N_W-1:0]    wn;
        logic [DD_W-1:0]   wdd;
        logic [BM_W-1:0]   bm;
        logic [VV_W-1:0]   vv;
        logic [TIME_W-1:0] now;
    } sq_tag_t;

    typedef struct packed {
        logic              kill;
        logic              neg;
        logic [TIME_W-1:0] now;
    } dv_tag_t;

endpackage
`default_nettype wire

>>> rtl/pcp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcp_front
// six stage front end: differences, products, dot sums, wide products,
// discriminant; wall numerator and divisor set up alongside
// ---------------------------------------------------------------------------
module pcp_front
    import pcp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire in_item_t         in_item,
    input  wire logic [GAP_W-1:0] gap_margin,
    output logic                  out_valid,
    output logic [D_W-1:0]        out_d,
    output sq_tag_t               out_tag
);

    // stage a
    logic                a_valid_reg;
    logic signed [17:0]  a_dx_reg, a_dy_reg;
    logic signed [19:0]  a_dvx_reg, a_dvy_reg;
    logic [16:0]         a_s_reg;
    sq_tag_t             a_tag_reg;

    logic signed [17:0]  a_dx_next, a_dy_next;
    logic signed [19:0]  a_dvx_next, a_dvy_next;
    logic [16:0]         a_s_next;
    sq_tag_t             a_tag_next;

    logic [POS_W-1:0]    w_p;
    logic [VEL_W-1:0]    w_v;
    logic signed [19:0]  w_num_pos, w_num_neg, w_sel, w_abs, w_vext, w_vabs;
    logic                w_vpos;

    assign a_dx_next  = $signed({1'b0, in_item.pos_x_b}) - $signed({1'b0, in_item.pos_x_a});
    assign a_dy_next  = $signed({1'b0, in_item.pos_y_b}) - $signed({1'b0, in_item.pos_y_a});
    assign a_dvx_next = $signed({in_item.vel_x_b[VEL_W-1], in_item.vel_x_b})
                      - $signed({in_item.vel_x_a[VEL_W-1], in_item.vel_x_a});
    assign a_dvy_next = $signed({in_item.vel_y_b[VEL_W-1], in_item.vel_y_b})
                      - $signed({in_item.vel_y_a[VEL_W-1], in_item.vel_y_a});
    assign a_s_next   = {2'b00, in_item.radius_a} + {2'b00, in_item.radius_b}
                      + {7'b0, gap_margin};

    always_comb
    begin
        w_p = (in_item.kind == KIND_WALL_X) ? in_item.pos_x_a : in_item.pos_y_a;
        w_v = (in_item.kind == KIND_WALL_X) ? in_item.vel_x_a : in_item.vel_y_a;
        w_vpos    = !w_v[VEL_W-1] && (w_v != '0);
        w_num_pos = WALL_ONE - $signed({5'b0, in_item.radius_a}) - $signed({3'b0, w_p});
        w_num_neg = $signed({3'b0, w_p}) - $signed({5'b0, in_item.radius_a});
        w_sel     = w_vpos ? w_num_pos : w_num_neg;
        w_abs     = w_sel[19] ? -w_sel : w_sel;
        w_vext    = {w_v[VEL_W-1], w_v};
        w_vabs    = w_vext[19] ? -w_vext : w_vext;

        a_tag_next      = '0;
        a_tag_next.now  = in_item.now;
        a_tag_next.wneg = w_vpos && w_num_pos[19];
        a_tag_next.wn   = N_W'(w_abs[18:0]);
        a_tag_next.wdd  = DD_W'(w_vabs[18:0]);
        case (in_item.kind)
            KIND_BALL:
            begin
                a_tag_next.ball = 1'b1;
            end
            KIND_WALL_X, KIND_WALL_Y:
            begin
                a_tag_next.kill = (w_v == '0);
            end
            default:
            begin
                a_tag_next.kill = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
            a_dvx_reg <= a_dvx_next;
            a_dvy_reg <= a_dvy_next;
            a_s_reg   <= a_s_next;
            a_tag_reg <= a_tag_next;
        end
    end

    // stage b: products
    logic               b_valid_reg;
    logic signed [37:0] b_bx_reg, b_by_reg;
    logic [38:0]        b_vx2_reg, b_vy2_reg;
    logic [34:0]        b_px2_reg, b_py2_reg;
    logic [33:0]        b_ss_reg;
    sq_tag_t            b_tag_reg;

    logic signed [37:0] b_bx_next, b_by_next;
    logic signed [39:0] b_vx2_next, b_vy2_next;
    logic signed [35:0] b_px2_next, b_py2_next;
    logic [33:0]        b_ss_next;

    assign b_bx_next  = a_dx_reg * a_dvx_reg;
    assign b_by_next  = a_dy_reg * a_dvy_reg;
    assign b_vx2_next = a_dvx_reg * a_dvx_reg;
    assign b_vy2_next = a_dvy_reg * a_dvy_reg;
    assign b_px2_next = a_dx_reg * a_dx_reg;
    assign b_py2_next = a_dy_reg * a_dy_reg;
    assign b_ss_next  = {17'b0, a_s_reg} * {17'b0, a_s_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_bx_reg  <= b_bx_next;
            b_by_reg  <= b_by_next;
            b_vx2_reg <= b_vx2_next[38:0];
            b_vy2_reg <= b_vy2_next[38:0];
            b_px2_reg <= b_px2_next[34:0];
            b_py2_reg <= b_py2_next[34:0];
            b_ss_reg  <= b_ss_next;
            b_tag_reg <= a_tag_reg;
        end
    end

    // stage c: dot sums
    logic               c_valid_reg;
    logic signed [37:0] c_b_reg;
    logic signed [36:0] c_c_reg;
    sq_tag_t            c_tag_reg;

    logic signed [37:0] c_b_next;
    logic [35:0]        c_pp_next;
    logic signed [36:0] c_c_next;
    sq_tag_t            c_tag_next;

    always_comb
    begin
        c_b_next   = b_bx_reg + b_by_reg;
        c_pp_next  = {1'b0, b_px2_reg} + {1'b0, b_py2_reg};
        c_c_next   = $signed({1'b0, c_pp_next}) - $signed({3'b0, b_ss_reg});
        c_tag_next = b_tag_reg;
        c_tag_next.vv = {1'b0, b_vx2_reg} + {1'b0, b_vy2_reg};
        if (b_tag_reg.ball && !c_b_next[37])
        begin
            c_tag_next.kill = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_b_reg   <= c_b_next;
            c_c_reg   <= c_c_next;
            c_tag_reg <= c_tag_next;
        end
    end

    // stage d: partial products of b*b and vv*|c|
    logic        d_valid_reg;
    logic        d_cpos_reg;
    logic [35:0] d_p_hh_reg;
    logic [36:0] d_p_hl_reg;
    logic [37:0] d_p_ll_reg;
    logic [36:0] d_q_hh_reg;
    logic [37:0] d_q_hl_reg;
    logic [36:0] d_q_lh_reg;
    logic [37:0] d_q_ll_reg;
    sq_tag_t     d_tag_reg;

    logic signed [37:0] d_negb;
    logic signed [36:0] d_absc;
    logic [BM_W-1:0]    d_bm;
    logic [34:0]        d_cm;
    sq_tag_t            d_tag_next;

    always_comb
    begin
        d_negb = -c_b_reg;
        d_absc = c_c_reg[36] ? -c_c_reg : c_c_reg;
        d_bm   = d_negb[BM_W-1:0];
        d_cm   = d_absc[34:0];
        d_tag_next    = c_tag_reg;
        d_tag_next.bm = d_bm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_cpos_reg <= !c_c_reg[36] && (c_c_reg != '0);
            d_p_hh_reg <= {18'b0, d_bm[36:19]} * {18'b0, d_bm[36:19]};
            d_p_hl_reg <= {19'b0, d_bm[36:19]} * {18'b0, d_bm[18:0]};
            d_p_ll_reg <= {19'b0, d_bm[18:0]} * {19'b0, d_bm[18:0]};
            d_q_hh_reg <= {17'b0, c_tag_reg.vv[39:20]} * {20'b0, d_cm[34:18]};
            d_q_hl_reg <= {18'b0, c_tag_reg.vv[39:20]} * {20'b0, d_cm[17:0]};
            d_q_lh_reg <= {17'b0, c_tag_reg.vv[19:0]} * {20'b0, d_cm[34:18]};
            d_q_ll_reg <= {18'b0, c_tag_reg.vv[19:0]} * {20'b0, d_cm[17:0]};
            d_tag_reg  <= d_tag_next;
        end
    end

    // stage e: sum partial products
    logic           e_valid_reg;
    logic           e_cpos_reg;
    logic [D_W-1:0] e_bb_reg, e_w_reg;
    sq_tag_t        e_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_cpos_reg <= d_cpos_reg;
            e_bb_reg   <= (D_W'(d_p_hh_reg) << 38) + (D_W'(d_p_hl_reg) << 20)
                        + D_W'(d_p_ll_reg);
            e_w_reg    <= (D_W'(d_q_hh_reg) << 38) + (D_W'(d_q_hl_reg) << 20)
                        + (D_W'(d_q_lh_reg) << 18) + D_W'(d_q_ll_reg);
            e_tag_reg  <= d_tag_reg;
        end
    end

    // stage f: discriminant
    logic           f_valid_reg;
    logic [D_W-1:0] f_d_reg;
    sq_tag_t        f_tag_reg;
    sq_tag_t        f_tag_next;

    always_comb
    begin
        f_tag_next = e_tag_reg;
        if (e_tag_reg.ball && e_cpos_reg && (e_w_reg > e_bb_reg))
        begin
            f_tag_next.kill = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_d_reg   <= e_cpos_reg ? (e_bb_reg - e_w_reg) : (e_bb_reg + e_w_reg);
            f_tag_reg <= f_tag_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_d     = f_d_reg;
    assign out_tag   = f_tag_reg;

endmodule
`default_nettype wire

>>> rtl/pcp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcp_sqrt
// pipelined floor square root, one root bit per stage
// ---------------------------------------------------------------------------
module pcp_sqrt
    import pcp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [D_W-1:0] in_d,
    input  wire sq_tag_t        in_tag,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output sq_tag_t             out_tag
);

    logic              v_reg   [ROOT_W];
    logic [D_W-1:0]    rem_reg [ROOT_W];
    logic [ROOT_W-1:0] r_reg   [ROOT_W];
    sq_tag_t           tag_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - i;

        logic              v_in;
        logic [D_W-1:0]    rem_in;
        logic [ROOT_W-1:0] r_in;
        sq_tag_t           tag_in;
        logic [D_W:0]      trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_d;
            assign r_in   = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign v_in   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign r_in   = r_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        // (r + 2^k)^2 - r^2
        assign trial = ((D_W+1)'(r_in) << (K + 1)) | ((D_W+1)'(1) << (2 * K));
        assign ge    = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? (rem_in - trial[D_W-1:0]) : rem_in;
                r_reg[i]   <= ge ? (r_in | (ROOT_W'(1) << K)) : r_in;
                tag_reg[i] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = r_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule
`default_nettype wire

>>> rtl/pcp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcp_div
// pipelined restoring divider, n * 2^frac / dd truncated, one quotient bit
// per stage, held at the time cap on overflow or zero divisor
// ---------------------------------------------------------------------------
module pcp_div
    import pcp_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [N_W-1:0]  in_n,
    input  wire logic [DD_W-1:0] in_dd,
    input  wire dv_tag_t         in_tag,
    output logic                 out_valid,
    output logic [MAG_W-1:0]     out_mag,
    output dv_tag_t              out_tag
);

    // pre stage: integer part check
    logic             p_valid_reg;
    logic             p_ovf_reg;
    logic [DD_W-1:0]  p_rem_reg;
    logic [DD_W-1:0]  p_dd_reg;
    logic [INT_W-1:0] p_nlo_reg;
    dv_tag_t          p_tag_reg;
    logic [DD_W-1:0]  p_hi;

    assign p_hi = DD_W'(in_n[N_W-1:INT_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ovf_reg <= (in_dd == '0) || (p_hi >= in_dd);
            p_rem_reg <= p_hi;
            p_dd_reg  <= in_dd;
            p_nlo_reg <= in_n[INT_W-1:0];
            p_tag_reg <= in_tag;
        end
    end

    logic             v_reg   [Q_W];
    logic             ovf_reg [Q_W];
    logic [DD_W-1:0]  rem_reg [Q_W];
    logic [DD_W-1:0]  dd_reg  [Q_W];
    logic [INT_W-1:0] nlo_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    dv_tag_t          tag_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        localparam int J = Q_W - 1 - i;

        logic             v_in;
        logic             ovf_in;
        logic [DD_W-1:0]  rem_in;
        logic [DD_W-1:0]  dd_in;
        logic [INT_W-1:0] nlo_in;
        logic [Q_W-1:0]   q_in;
        dv_tag_t          tag_in;
        logic             nbit;
        logic [DD_W:0]    t;
        logic [DD_W:0]    diff;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign v_in   = p_valid_reg;
            assign ovf_in = p_ovf_reg;
            assign rem_in = p_rem_reg;
            assign dd_in  = p_dd_reg;
            assign nlo_in = p_nlo_reg;
            assign q_in   = '0;
            assign tag_in = p_tag_reg;
        end
        else
        begin : g_next
            assign v_in   = v_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign dd_in  = dd_reg[i-1];
            assign nlo_in = nlo_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        if (J >= FRAC_BITS)
        begin : g_nbit
            assign nbit = nlo_in[J-FRAC_BITS];
        end
        else
        begin : g_zbit
            assign nbit = 1'b0;
        end

        assign t    = {rem_in, nbit};
        assign diff = t - {1'b0, dd_in};
        assign ge   = t >= {1'b0, dd_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[i] <= ovf_in;
                rem_reg[i] <= ge ? diff[DD_W-1:0] : t[DD_W-1:0];
                dd_reg[i]  <= dd_in;
                nlo_reg[i] <= nlo_in;
                q_reg[i]   <= ge ? (q_in | (Q_W'(1) << J)) : q_in;
                tag_reg[i] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_mag   = ovf_reg[Q_W-1] ? MAG_CAP : {1'b0, q_reg[Q_W-1]};
    assign out_tag   = tag_reg[Q_W-1];

endmodule
`default_nettype wire

>>> rtl/particle_collision_time_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// particle_collision_time_predictor
// predicts the absolute time at which a disc hits another disc or a wall
// ---------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tuser kind; tdata disc a, disc b, now
// m_*       out  tuser hit; tdata event_time
// cfg_*     in   write of horizon (index 0) or gap_margin (index 1)
//
// one item per cycle when not stalled, through 6 front stages, 38 square root
// stages, 1 select stage, 41 divider stages and the output register
// the square root and the divider set the depth, one bit per stage
// whole pipeline advances when the output register is empty or taken
// reset clears the valid bits and loads the register defaults
// ---------------------------------------------------------------------------
module particle_collision_time_predictor
    import pcp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pos_x_a, pos_y_a, vel_x_a, vel_y_a, radius_a, pos_x_b, pos_y_b,
    // vel_x_b, vel_y_b, radius_b, now, zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]   s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // event_time, zero fill
    output logic [M_DATA_W-1:0]      m_tdata,
    // hit
    output logic [0:0]               m_tuser,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [HOR_W-1:0]    cfg_data
);

    logic             en;
    logic [HOR_W-1:0] horizon_reg;
    logic [GAP_W-1:0] gap_reg;
    in_item_t         item;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        item          = '0;
        item.kind     = s_tuser;
        item.pos_x_a  = s_tdata[16:0];
        item.pos_y_a  = s_tdata[33:17];
        item.vel_x_a  = s_tdata[52:34];
        item.vel_y_a  = s_tdata[71:53];
        item.radius_a = s_tdata[86:72];
        item.pos_x_b  = s_tdata[103:87];
        item.pos_y_b  = s_tdata[120:104];
        item.vel_x_b  = s_tdata[139:121];
        item.vel_y_b  = s_tdata[158:140];
        item.radius_b = s_tdata[173:159];
        item.now      = s_tdata[196:174];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= HORIZON_RESET;
            gap_reg     <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HORIZON: horizon_reg <= cfg_data;
                CFG_GAP:     gap_reg     <= cfg_data[GAP_W-1:0];
                default:     horizon_reg <= horizon_reg;
            endcase
        end
    end

    logic           fr_valid;
    logic [D_W-1:0] fr_d;
    sq_tag_t        fr_tag;

    pcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_item    (item),
        .gap_margin (gap_reg),
        .out_valid  (fr_valid),
        .out_d      (fr_d),
        .out_tag    (fr_tag)
    );

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_tag_t           sq_tag;

    pcp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_d      (fr_d),
        .in_tag    (fr_tag),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // select numerator and divisor for the divider
    logic            sel_valid_reg;
    logic [N_W-1:0]  sel_n_reg;
    logic [DD_W-1:0] sel_dd_reg;
    dv_tag_t         sel_tag_reg;
    logic            sel_over;
    logic [N_W-1:0]  sel_bm;

    assign sel_bm   = N_W'(sq_tag.bm);
    assign sel_over = sq_root > sel_bm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_tag_reg.kill <= sq_tag.kill;
            sel_tag_reg.now  <= sq_tag.now;
            if (sq_tag.ball)
            begin
                sel_n_reg       <= sel_over ? (sq_root - sel_bm) : (sel_bm - sq_root);
                sel_dd_reg      <= sq_tag.vv;
                sel_tag_reg.neg <= sel_over;
            end
            else
            begin
                sel_n_reg       <= sq_tag.wn;
                sel_dd_reg      <= sq_tag.wdd;
                sel_tag_reg.neg <= sq_tag.wneg;
            end
        end
    end

    logic             dv_valid;
    logic [MAG_W-1:0] dv_mag;
    dv_tag_t          dv_tag;

    pcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_valid_reg),
        .in_n      (sel_n_reg),
        .in_dd     (sel_dd_reg),
        .in_tag    (sel_tag_reg),
        .out_valid (dv_valid),
        .out_mag   (dv_mag),
        .out_tag   (dv_tag)
    );

    // horizon check, absolute time and saturation
    logic                    fin_hit;
    logic signed [EVX_W-1:0] fin_ev;
    logic signed [EVX_W-1:0] fin_sat;
    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [EV_W-1:0]         out_ev_reg;

    always_comb
    begin
        fin_hit = !dv_tag.kill && (dv_tag.neg || (dv_mag <= MAG_W'(horizon_reg)));
        if (dv_tag.neg)
        begin
            fin_ev = $signed(EVX_W'(dv_tag.now)) - $signed(EVX_W'(dv_mag));
        end
        else
        begin
            fin_ev = $signed(EVX_W'(dv_tag.now)) + $signed(EVX_W'(dv_mag));
        end
        if (fin_ev > EV_MAX)
        begin
            fin_sat = EV_MAX;
        end
        else if (fin_ev < EV_MIN)
        begin
            fin_sat = EV_MIN;
        end
        else
        begin
            fin_sat = fin_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= fin_hit;
            out_ev_reg  <= fin_hit ? fin_sat[EV_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {{(M_DATA_W - EV_W){1'b0}}, out_ev_reg};

`ifndef SYNTHESIS
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[EV_W-1:0] == '0)
        else $error("result without hit carries a nonzero time");

    a_future_event: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && fin_hit && !dv_tag.neg |-> fin_sat >= $signed(EVX_W'(dv_tag.now)))
        else $error("forward event placed before current time");

    a_freeze_div: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_valid) && $stable(dv_mag))
        else $error("divider output moved during a stall");

    a_freeze_sel: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sel_valid_reg) && $stable(sel_n_reg))
        else $error("select stage moved during a stall");
`endif

endmodule
`default_nettype wire
